### rtl/core/rtbs_pkg.sv
// Shared constants, types and command/status structs for the regression
// tree best-split block. Depends on nothing.
package rtbs_pkg;

    localparam int MAX_ROWS     = 1024;
    localparam int MAX_FEATURES = 64;
    localparam int VAL_W        = 32;
    localparam int TGT_W        = 16;
    localparam int FEAT_W       = 6;
    localparam int ADDR_W       = $clog2(MAX_ROWS);
    localparam int CNT_W        = $clog2(MAX_ROWS + 1);
    localparam int COL_W        = $clog2(MAX_FEATURES);
    localparam int SUM_W        = TGT_W + CNT_W;
    localparam int SQ_W         = 2 * SUM_W;
    localparam int SCORE_W      = SQ_W + 1;
    localparam int DCNT_W       = $clog2(SQ_W + 1);

    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic signed [TGT_W-1:0] tgt;
    } t_entry;

    typedef struct packed {
        logic load;
        logic shift;
        logic write;
        logic scan0;
        logic adv;
        logic sq_l;
        logic sq_r;
        logic take_l;
        logic upd;
        logic nextcol;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic gt;
        logic j_one;
        logic k_zero;
        logic differ;
        logic last;
        logic short_col;
        logic div_busy;
        logic out_full;
        logic eoc;
        logic eos;
    } t_stat;

endpackage

### rtl/core/rtbs_if.sv
// Handshake interfaces for the sample and result channels.
// Depends on rtbs_pkg for field widths.
interface rtbs_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rtbs_pkg::VAL_W-1:0]      feature_value;
    logic signed [rtbs_pkg::TGT_W-1:0]      target_value;
    logic                                   last_of_column;
    logic                                   last_of_set;

    modport source (output valid, feature_value, target_value, last_of_column,
                    last_of_set, input ready);
    modport sink (input valid, feature_value, target_value, last_of_column,
                  last_of_set, output ready);
endinterface

interface rtbs_result_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   split_found;
    logic [rtbs_pkg::FEAT_W-1:0]            best_feature;
    logic signed [rtbs_pkg::VAL_W-1:0]      threshold;
    logic                                   overflow;

    modport source (output valid, split_found, best_feature, threshold, overflow,
                    input ready);
    modport sink (input valid, split_found, best_feature, threshold, overflow,
                  output ready);
endinterface

### rtl/core/rtbs_div.sv
// Restoring divider, one quotient bit per cycle, for the split score terms.
// Depends on rtbs_pkg.
module rtbs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rtbs_pkg::SQ_W-1:0]   i_dividend,
    input  logic [rtbs_pkg::CNT_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic [rtbs_pkg::SQ_W-1:0]   o_quot
);
    import rtbs_pkg::*;

    logic [SQ_W-1:0]   r_quot;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign trial = {r_rem, r_quot[SQ_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(SQ_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[SQ_W-2:0], ge};
            r_rem  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;
endmodule

### rtl/core/rtbs_ctrl.sv
// Sequencer for load-time insertion, column scan and result emission.
// Depends on rtbs_pkg; drives the datapath by command struct.
module rtbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rtbs_pkg::t_stat i_stat,
    output logic            o_ready,
    output rtbs_pkg::t_cmd  o_cmd
);
    import rtbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SHIFT, S_WRITE, S_COLEND, S_SCAN, S_DIVL, S_DIVR, S_NEXTCOL, S_OUT
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.full)       n_state = S_COLEND;
                    else if (i_stat.empty) n_state = S_WRITE;
                    else                   n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_stat.gt) begin
                    o_cmd.shift = 1'b1;
                    if (i_stat.j_one) n_state = S_WRITE;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_COLEND;
            end
            S_COLEND: begin
                if (!i_stat.eoc) begin
                    n_state = S_IDLE;
                end else if (i_stat.short_col) begin
                    n_state = S_NEXTCOL;
                end else begin
                    o_cmd.scan0 = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.k_zero || !i_stat.differ) begin
                    o_cmd.adv = 1'b1;
                    if (i_stat.last) n_state = S_NEXTCOL;
                end else begin
                    o_cmd.sq_l = 1'b1;
                    n_state    = S_DIVL;
                end
            end
            S_DIVL: begin
                if (!i_stat.div_busy) begin
                    o_cmd.take_l = 1'b1;
                    o_cmd.sq_r   = 1'b1;
                    n_state      = S_DIVR;
                end
            end
            S_DIVR: begin
                if (!i_stat.div_busy) begin
                    o_cmd.upd = 1'b1;
                    o_cmd.adv = 1'b1;
                    n_state   = i_stat.last ? S_NEXTCOL : S_SCAN;
                end
            end
            S_NEXTCOL: begin
                o_cmd.nextcol = 1'b1;
                n_state       = i_stat.eos ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### rtl/core/rtbs_dp.sv
// Datapath: column memory, sums, score divider, best-split and result registers.
// Depends on rtbs_pkg, rtbs_if and rtbs_div.
module rtbs_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic signed [rtbs_pkg::VAL_W-1:0] i_feature_value,
    input  logic signed [rtbs_pkg::TGT_W-1:0] i_target_value,
    input  logic                             i_last_of_column,
    input  logic                             i_last_of_set,
    input  rtbs_pkg::t_cmd                   i_cmd,
    output rtbs_pkg::t_stat                  o_stat,
    rtbs_result_if.source                    o_result
);
    import rtbs_pkg::*;

    t_entry mem [MAX_ROWS];

    t_entry                  r_rd;
    t_entry                  r_new;
    t_entry                  r_prev;
    logic                    r_eoc;
    logic                    r_eos;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_j;
    logic [CNT_W-1:0]        r_k;
    logic signed [SUM_W-1:0] r_total;
    logic signed [SUM_W-1:0] r_left;
    logic [SQ_W-1:0]         r_acc;
    logic [COL_W-1:0]        r_col;
    logic [SCORE_W-1:0]      r_best_score;
    logic                    r_best_valid;
    logic [COL_W-1:0]        r_best_col;
    logic signed [VAL_W-1:0] r_best_thr;
    logic                    r_ovf;
    logic                    r_out_valid;

    logic                    rd_en;
    logic [CNT_W-1:0]        rd_addr;
    logic                    wr_en;
    t_entry                  wr_data;
    logic signed [SUM_W-1:0] sum_sel;
    logic [SUM_W-1:0]        mag;
    logic [SQ_W-1:0]         square;
    logic [CNT_W-1:0]        den;
    logic                    div_busy;
    logic [SQ_W-1:0]         quot;
    logic [SCORE_W-1:0]      score;

    // memory addressing per command
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = '0;
        if (i_cmd.load)       rd_addr = r_count - 1'b1;
        else if (i_cmd.shift) rd_addr = r_j - CNT_W'(2);
        else if (i_cmd.adv)   rd_addr = r_k + 1'b1;
        else if (!i_cmd.scan0) rd_en  = 1'b0;
        wr_en   = i_cmd.shift || i_cmd.write;
        wr_data = i_cmd.shift ? r_rd : r_new;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_j[ADDR_W-1:0]] <= wr_data;
        if (rd_en) r_rd <= mem[rd_addr[ADDR_W-1:0]];
    end

    assign sum_sel = i_cmd.sq_l ? r_left : (r_total - r_left);
    assign mag     = sum_sel < 0 ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    assign square  = mag * mag;
    assign den     = i_cmd.sq_l ? r_k : (r_count - r_k);
    assign score   = {1'b0, r_acc} + {1'b0, quot};

    rtbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sq_l || i_cmd.sq_r),
        .i_dividend (square),
        .i_divisor  (den),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new.val <= i_feature_value;
            r_new.tgt <= i_target_value;
            r_eoc     <= i_last_of_column || i_last_of_set;
            r_eos     <= i_last_of_set;
        end
        if (i_cmd.load)  r_j <= r_count;
        if (i_cmd.shift) r_j <= r_j - 1'b1;
        if (i_cmd.scan0) begin
            r_k    <= '0;
            r_left <= '0;
        end
        if (i_cmd.adv) begin
            r_prev <= r_rd;
            r_left <= r_left + SUM_W'(r_rd.tgt);
            r_k    <= r_k + 1'b1;
        end
        if (i_cmd.take_l) r_acc <= quot;
        if (i_cmd.emit) begin
            o_result.split_found  <= r_best_valid;
            o_result.best_feature <= r_best_valid ? FEAT_W'(r_best_col) : '0;
            o_result.threshold    <= r_best_valid ? r_best_thr : '0;
            o_result.overflow     <= r_ovf;
        end
    end

    // set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_total      <= '0;
            r_col        <= '0;
            r_best_score <= '0;
            r_best_valid <= 1'b0;
            r_best_col   <= '0;
            r_best_thr   <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load && r_count == CNT_W'(MAX_ROWS)) r_ovf <= 1'b1;
            if (i_cmd.write) begin
                r_count <= r_count + 1'b1;
                r_total <= r_total + SUM_W'(r_new.tgt);
            end
            if (i_cmd.upd && (!r_best_valid || score > r_best_score)) begin
                r_best_valid <= 1'b1;
                r_best_score <= score;
                r_best_col   <= r_col;
                r_best_thr   <= r_prev.val;
            end
            if (i_cmd.nextcol) begin
                r_count <= '0;
                r_total <= '0;
                r_col   <= (r_col == COL_W'(MAX_FEATURES - 1)) ? '0 : r_col + 1'b1;
            end
            if (i_cmd.emit) begin
                r_col        <= '0;
                r_best_score <= '0;
                r_best_valid <= 1'b0;
                r_best_col   <= '0;
                r_best_thr   <= '0;
                r_ovf        <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid = r_out_valid;

    assign o_stat.full      = r_count == CNT_W'(MAX_ROWS);
    assign o_stat.empty     = r_count == '0;
    assign o_stat.gt        = r_rd.val > r_new.val;
    assign o_stat.j_one     = r_j == CNT_W'(1);
    assign o_stat.k_zero    = r_k == '0;
    assign o_stat.differ    = r_rd.val != r_prev.val;
    assign o_stat.last      = (r_k + 1'b1) == r_count;
    assign o_stat.short_col = r_count < CNT_W'(2);
    assign o_stat.div_busy  = div_busy;
    assign o_stat.out_full  = r_out_valid && !o_result.ready;
    assign o_stat.eoc       = r_eoc;
    assign o_stat.eos       = r_eos;
endmodule

### rtl/core/regression_tree_best_split.sv
// Top level of the regression tree best-split finder.
// Depends on rtbs_pkg, rtbs_if, rtbs_ctrl and rtbs_dp.
//
// Usage: samples arrive on i_sample, one (feature value, target) item per
// handshake, column by column; last_of_column closes a column and last_of_set
// closes the whole set. One result item leaves on o_result per set: whether a
// split exists, its column and its threshold (greater values go right), and
// an overflow flag for columns longer than MAX_ROWS (extra samples dropped).
// Timing: each sample is inserted in sorted order into the column memory as
// it arrives, walking the memory one entry a cycle past the entries greater than
// it. At column end the scan reads one entry a cycle, except that every
// value-change boundary holds it for two serial divisions (left and right
// terms). The divider sets the scan cost and the memory walk sets the load cost.
// Ready is high only while idle.
// The result sits in an output register; a stalled receiver blocks the next
// set only when its own result is ready, earlier samples still load.
// Reset (synchronous, active low) clears the set state and the output valid;
// the column memory needs no clearing since only written rows are used.
module regression_tree_best_split (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rtbs_sample_if.sink   i_sample,
    rtbs_result_if.source o_result
);
    import rtbs_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  ready;

    // sequence the column work
    rtbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_sample.valid),
        .i_stat  (stat),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    // hold the column, sums and best split
    rtbs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_feature_value  (i_sample.feature_value),
        .i_target_value   (i_sample.target_value),
        .i_last_of_column (i_sample.last_of_column),
        .i_last_of_set    (i_sample.last_of_set),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_result         (o_result)
    );

    assign i_sample.ready = ready;
endmodule

### rtl/core/rtbs_checker.sv
// Port-level checks for regression_tree_best_split, bound to the top level.
// Depends on rtbs_pkg.
module rtbs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_split_found,
    input logic [rtbs_pkg::FEAT_W-1:0]   i_best_feature,
    input logic [rtbs_pkg::VAL_W-1:0]    i_threshold
);
    // hold valid and threshold of a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_threshold))
        else $error("stalled result changed");

    // drop valid out of reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an accepted item always drops ready in the cycle after the accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after accept");

    // no split means zero column and threshold
    a_nosplit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_split_found |-> i_best_feature == '0 && i_threshold == '0)
        else $error("no-split result carries data");
endmodule

bind regression_tree_best_split rtbs_checker u_rtbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_sample.valid),
    .i_in_ready     (i_sample.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_split_found  (o_result.split_found),
    .i_best_feature (o_result.best_feature),
    .i_threshold    (o_result.threshold)
);
